// File: design/ilp_pkg.sv
// shared types and constants for the intra 16x16 luma predictor
// no dependencies
`timescale 1ns / 1ps

package ilp_pkg;

  localparam int SAMPLE_BITS = 8;
  localparam int PIX_MAX     = (1 << SAMPLE_BITS) - 1;
  localparam int BLK_DIM     = 16;
  localparam int HALF_PIX    = 8;
  localparam int BEATS       = 32;
  localparam int BEAT_BITS   = $clog2(BEATS);

  typedef logic [SAMPLE_BITS-1:0] pix_t;

  typedef enum logic [1:0] {
    MODE_VERT  = 2'd0,
    MODE_HORZ  = 2'd1,
    MODE_DC    = 2'd2,
    MODE_PLANE = 2'd3
  } pred_mode_t;

  // per-block values handed from the setup pipeline to the emitter
  typedef struct packed {
    pred_mode_t           mode;
    logic                 top_avail;
    pix_t [BLK_DIM-1:0]   top;
    pix_t [BLK_DIM-1:0]   left;
    pix_t                 dc;
    logic [12:0]          a;
    logic signed [10:0]   b;
    logic signed [10:0]   c;
  } blk_params_t;

endpackage

// File: design/ilp_if.sv
// valid/ready channels for neighbour items and predicted half-rows
// no dependencies
`timescale 1ns / 1ps

interface ilp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] top_px_0_3;
  logic [31:0] top_px_4_7;
  logic [31:0] top_px_8_11;
  logic [31:0] top_px_12_15;
  logic [31:0] left_px_0_3;
  logic [31:0] left_px_4_7;
  logic [31:0] left_px_8_11;
  logic [31:0] left_px_12_15;
  logic [7:0]  corner_px;
  logic [1:0]  pred_mode;
  logic        top_avail;
  logic        left_avail;

  modport source (
    output valid, top_px_0_3, top_px_4_7, top_px_8_11, top_px_12_15,
           left_px_0_3, left_px_4_7, left_px_8_11, left_px_12_15,
           corner_px, pred_mode, top_avail, left_avail,
    input  ready
  );

  modport sink (
    input  valid, top_px_0_3, top_px_4_7, top_px_8_11, top_px_12_15,
           left_px_0_3, left_px_4_7, left_px_8_11, left_px_12_15,
           corner_px, pred_mode, top_avail, left_avail,
    output ready
  );
endinterface

interface ilp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  row_index;
  logic        half_index;
  logic [31:0] pixels_first4;
  logic [31:0] pixels_last4;
  logic        block_last;

  modport source (
    output valid, row_index, half_index, pixels_first4, pixels_last4, block_last,
    input  ready
  );

  modport sink (
    input  valid, row_index, half_index, pixels_first4, pixels_last4, block_last,
    output ready
  );
endinterface

// File: design/ilp_setup.sv
// four-stage pipeline from neighbour beat to per-block prediction values
// depends on ilp_pkg and ilp_in_if
`timescale 1ns / 1ps

module ilp_setup (
  input  logic                clk,
  input  logic                rst_n,
  ilp_in_if.sink              in_ch,
  output logic                prm_valid,
  input  logic                prm_ready,
  output ilp_pkg::blk_params_t prm_data
);
  import ilp_pkg::*;

  // stage valids and readies
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  assign s4_rdy = !s4_v_r || prm_ready;
  assign s3_rdy = !s3_v_r || s4_rdy;
  assign s2_rdy = !s2_v_r || s3_rdy;
  assign s1_rdy = !s1_v_r || s2_rdy;
  assign in_ch.ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_ch.valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (s4_rdy) s4_v_r <= s3_v_r;
    end
  end

  // stage 1: unpack, mask missing left column
  logic [16*SAMPLE_BITS-1:0] top_bits, left_bits;
  pix_t [BLK_DIM-1:0] top1_r, left1_r;
  pix_t               corner1_r;
  pred_mode_t         mode1_r;
  logic               tav1_r, lav1_r;

  assign top_bits  = {in_ch.top_px_12_15, in_ch.top_px_8_11,
                      in_ch.top_px_4_7, in_ch.top_px_0_3};
  assign left_bits = {in_ch.left_px_12_15, in_ch.left_px_8_11,
                      in_ch.left_px_4_7, in_ch.left_px_0_3};

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      for (int k = 0; k < BLK_DIM; k++) begin
        top1_r[k]  <= top_bits[k*SAMPLE_BITS +: SAMPLE_BITS];
        left1_r[k] <= in_ch.left_avail ? left_bits[k*SAMPLE_BITS +: SAMPLE_BITS] : '0;
      end
      corner1_r <= in_ch.corner_px;
      mode1_r   <= pred_mode_t'(in_ch.pred_mode);
      tav1_r    <= in_ch.top_avail;
      lav1_r    <= in_ch.left_avail;
    end
  end

  // stage 2: edge sums and weighted gradient terms
  logic [11:0]        st_nxt, sl_nxt;
  logic signed [8:0]  dh, dv;
  logic signed [12:0] wh_nxt [8];
  logic signed [12:0] wv_nxt [8];

  always_comb begin
    st_nxt = '0;
    sl_nxt = '0;
    for (int k = 0; k < BLK_DIM; k++) begin
      st_nxt = st_nxt + 12'(top1_r[k]);
      sl_nxt = sl_nxt + 12'(left1_r[k]);
    end
    for (int k = 0; k < 7; k++) begin
      dh = signed'({1'b0, top1_r[8+k]}) - signed'({1'b0, top1_r[6-k]});
      dv = signed'({1'b0, left1_r[8+k]}) - signed'({1'b0, left1_r[6-k]});
      wh_nxt[k] = dh * signed'(13'(k + 1));
      wv_nxt[k] = dv * signed'(13'(k + 1));
    end
    dh = signed'({1'b0, top1_r[15]}) - signed'({1'b0, corner1_r});
    dv = signed'({1'b0, left1_r[15]}) - signed'({1'b0, corner1_r});
    wh_nxt[7] = dh * 13'sd8;
    wv_nxt[7] = dv * 13'sd8;
  end

  logic [11:0]        st2_r, sl2_r;
  logic signed [12:0] wh2_r [8];
  logic signed [12:0] wv2_r [8];
  pix_t [BLK_DIM-1:0] top2_r, left2_r;
  pred_mode_t         mode2_r;
  logic               tav2_r, lav2_r;

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      st2_r   <= st_nxt;
      sl2_r   <= sl_nxt;
      wh2_r   <= wh_nxt;
      wv2_r   <= wv_nxt;
      top2_r  <= top1_r;
      left2_r <= left1_r;
      mode2_r <= mode1_r;
      tav2_r  <= tav1_r;
      lav2_r  <= lav1_r;
    end
  end

  // stage 3: gradients, dc value, plane offset
  logic signed [14:0] h_nxt, v_nxt;
  logic [12:0]        dsum;
  pix_t               dc_nxt;
  logic [12:0]        a_nxt;

  always_comb begin
    h_nxt = '0;
    v_nxt = '0;
    for (int k = 0; k < 8; k++) begin
      h_nxt = h_nxt + 15'(wh2_r[k]);
      v_nxt = v_nxt + 15'(wv2_r[k]);
    end
    dsum = '0;
    if (tav2_r && lav2_r) begin
      dsum   = 13'(st2_r) + 13'(sl2_r) + 13'd16;
      dc_nxt = dsum[12:5];
    end else if (tav2_r) begin
      dsum   = 13'(st2_r) + 13'd8;
      dc_nxt = dsum[11:4];
    end else if (lav2_r) begin
      dsum   = 13'(sl2_r) + 13'd8;
      dc_nxt = dsum[11:4];
    end else begin
      dc_nxt = pix_t'(1 << (SAMPLE_BITS - 1));
    end
    a_nxt = {(9'(left2_r[15]) + 9'(top2_r[15])), 4'b0000};
  end

  logic signed [14:0] h3_r, v3_r;
  pix_t               dc3_r;
  logic [12:0]        a3_r;
  pix_t [BLK_DIM-1:0] top3_r, left3_r;
  pred_mode_t         mode3_r;
  logic               tav3_r;

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      h3_r    <= h_nxt;
      v3_r    <= v_nxt;
      dc3_r   <= dc_nxt;
      a3_r    <= a_nxt;
      top3_r  <= top2_r;
      left3_r <= left2_r;
      mode3_r <= mode2_r;
      tav3_r  <= tav2_r;
    end
  end

  // stage 4: plane slopes (5*g + 32) >> 6, floor
  logic signed [17:0] hb, vc;
  blk_params_t        prm_r;

  always_comb begin
    hb = (18'(h3_r) <<< 2) + 18'(h3_r) + 18'sd32;
    vc = (18'(v3_r) <<< 2) + 18'(v3_r) + 18'sd32;
  end

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      prm_r.mode      <= mode3_r;
      prm_r.top_avail <= tav3_r;
      prm_r.top       <= top3_r;
      prm_r.left      <= left3_r;
      prm_r.dc        <= dc3_r;
      prm_r.a         <= a3_r;
      prm_r.b         <= 11'(hb >>> 6);
      prm_r.c         <= 11'(vc >>> 6);
    end
  end

  assign prm_valid = s4_v_r;
  assign prm_data  = prm_r;

endmodule

// File: design/ilp_emit.sv
// block holding register, half-row sequencer and output register
// depends on ilp_pkg and ilp_out_if
`timescale 1ns / 1ps

module ilp_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 prm_valid,
  output logic                 prm_ready,
  input  ilp_pkg::blk_params_t prm_data,
  ilp_out_if.source            out_ch
);
  import ilp_pkg::*;

  blk_params_t          p_r;
  logic                 p_v_r;
  logic [BEAT_BITS-1:0] cnt_r;
  logic                 g1_v_r, o_v_r;
  logic                 g1_rdy, o_rdy;
  logic                 issue, issue_last;

  assign o_rdy      = !o_v_r || out_ch.ready;
  assign g1_rdy     = !g1_v_r || o_rdy;
  assign issue      = p_v_r && g1_rdy;
  assign issue_last = issue && (&cnt_r);
  assign prm_ready  = !p_v_r || issue_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r  <= 1'b0;
      cnt_r  <= '0;
      g1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (prm_ready) p_v_r <= prm_valid;
      if (issue) cnt_r <= cnt_r + 1'b1;
      if (g1_rdy) g1_v_r <= issue;
      if (o_rdy) o_v_r <= g1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (prm_ready && prm_valid) p_r <= prm_data;
  end

  // half-row setup: plane start value at the first column of the half-row
  logic [3:0]         row;
  logic               half;
  logic signed [4:0]  ym7;
  logic signed [16:0] cy, bx, p0_nxt;
  pix_t [HALF_PIX-1:0] toph_nxt;

  assign row  = cnt_r[BEAT_BITS-1:1];
  assign half = cnt_r[0];

  always_comb begin
    ym7    = signed'({1'b0, row}) - 5'sd7;
    cy     = 17'(p_r.c) * 17'(ym7);
    bx     = half ? 17'(p_r.b) : 17'(p_r.b) * -17'sd7;
    p0_nxt = signed'(17'(p_r.a)) + 17'sd16 + cy + bx;
    for (int i = 0; i < HALF_PIX; i++) begin
      toph_nxt[i] = p_r.top_avail ? p_r.top[HALF_PIX*half + i] : '0;
    end
  end

  logic [3:0]          g1_row_r;
  logic                g1_half_r, g1_last_r;
  pred_mode_t          g1_mode_r;
  logic signed [16:0]  g1_p0_r;
  logic signed [10:0]  g1_b_r;
  pix_t [HALF_PIX-1:0] g1_top_r;
  pix_t                g1_left_r, g1_dc_r;

  always_ff @(posedge clk) begin
    if (g1_rdy) begin
      g1_row_r  <= row;
      g1_half_r <= half;
      g1_last_r <= &cnt_r;
      g1_mode_r <= p_r.mode;
      g1_p0_r   <= p0_nxt;
      g1_b_r    <= p_r.b;
      g1_top_r  <= toph_nxt;
      g1_left_r <= p_r.left[row];
      g1_dc_r   <= p_r.dc;
    end
  end

  // pixel generation and clipping
  logic signed [16:0]  pv, ps;
  pix_t [HALF_PIX-1:0] pix_nxt;

  always_comb begin
    for (int i = 0; i < HALF_PIX; i++) begin
      pv = g1_p0_r + 17'(g1_b_r) * signed'(17'(i));
      ps = pv >>> 5;
      case (g1_mode_r)
        MODE_VERT:  pix_nxt[i] = g1_top_r[i];
        MODE_HORZ:  pix_nxt[i] = g1_left_r;
        MODE_DC:    pix_nxt[i] = g1_dc_r;
        MODE_PLANE: begin
          if (ps < 0) pix_nxt[i] = '0;
          else if (ps > 17'sd255) pix_nxt[i] = pix_t'(PIX_MAX);
          else pix_nxt[i] = ps[SAMPLE_BITS-1:0];
        end
        default:    pix_nxt[i] = '0;
      endcase
    end
  end

  logic [3:0]          o_row_r;
  logic                o_half_r, o_last_r;
  pix_t [HALF_PIX-1:0] o_pix_r;

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      o_row_r  <= g1_row_r;
      o_half_r <= g1_half_r;
      o_last_r <= g1_last_r;
      o_pix_r  <= pix_nxt;
    end
  end

  assign out_ch.valid         = o_v_r;
  assign out_ch.row_index     = o_row_r;
  assign out_ch.half_index    = o_half_r;
  assign out_ch.pixels_first4 = o_pix_r[3:0];
  assign out_ch.pixels_last4  = o_pix_r[7:4];
  assign out_ch.block_last    = o_last_r;

endmodule

// File: design/intra_16x16_luma_predictor_unit.sv
// top level of the intra 16x16 luma predictor
// depends on ilp_pkg, ilp_if, ilp_setup and ilp_emit
`timescale 1ns / 1ps

// Usage:
// in_ch takes one beat per 16x16 block: top and left neighbours, corner,
// mode and the two availability flags. out_ch returns 32 beats per block,
// one half-row of eight pixels each, row by row, left half first;
// block_last marks the 32nd beat.
// Path: the first half-row of a block passes through the four setup
// stages, the block holding register, one half-row setup stage, then
// the output register.
// Throughput: one half-row per cycle while out_ch.ready stays high; the
// emitter reads one held block through a 5-bit half-row counter.
// Up to four further blocks queue in the setup stages while a block is
// being emitted; once they are full in_ch.ready stays low until the held
// block issues its last half-row.
// Reset (rst_n low, synchronous) empties all stages and clears the counter.
// When out_ch.ready is low the output register holds its beat and each full
// stage behind it holds its contents, so nothing is dropped or repeated.

module intra_16x16_luma_predictor_unit (
  input  logic       clk,
  input  logic       rst_n,
  ilp_in_if.sink     in_ch,
  ilp_out_if.source  out_ch
);
  import ilp_pkg::*;

  logic        prm_valid;
  logic        prm_ready;
  blk_params_t prm_data;

  ilp_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .prm_valid (prm_valid),
    .prm_ready (prm_ready),
    .prm_data  (prm_data)
  );

  ilp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .prm_valid (prm_valid),
    .prm_ready (prm_ready),
    .prm_data  (prm_data),
    .out_ch    (out_ch)
  );

endmodule

// File: verif/tb.sv
// self-checking testbench for intra_16x16_luma_predictor_unit: directed and random blocks,
// with every half-row compared against a local intra 16x16 prediction or a known fill value
// depends on ilp_pkg, ilp_if and the predictor rtl
`timescale 1ns / 1ps

module tb;
  import ilp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIR       = 23;
  localparam int HOLD_CYC    = 400;
  localparam int MAX_REPORTS = 10;

  localparam logic [127:0] ZERO    = '0;
  localparam logic [127:0] ALL_FF  = {16{8'hFF}};
  localparam logic [127:0] FLAT80  = {16{8'h80}};
  localparam logic [127:0] RAMP_UP = 128'hF0E0D0C0_B0A09080_70605040_30201000;
  localparam logic [127:0] RAMP_DN = 128'h0F1F2F3F_4F5F6F7F_8F9FAFBF_CFDFEFFF;
  localparam logic [127:0] MIX     = 128'h01234567_89ABCDEF_FEDCBA98_76543210;
  localparam logic [127:0] EDGE_HI = 128'hFFFFFFFF_FFFFFFFF_00000000_00000000;
  localparam logic [127:0] EDGE_LO = 128'h00000000_00000000_FFFFFFFF_FFFFFFFF;

  typedef struct packed {
    pred_mode_t   mode;
    logic         top_av;
    logic         left_av;
    pix_t         corner;
    logic [127:0] top;
    logic [127:0] left;
  } nbr_item_t;

  typedef struct packed {
    nbr_item_t item;
    logic      fixed;
    pix_t      fill;
  } dir_row_t;

  typedef struct packed {
    logic [3:0]  row;
    logic        half;
    logic [31:0] first4;
    logic [31:0] last4;
    logic        last;
  } half_row_t;

  typedef pix_t [BLK_DIM-1:0][BLK_DIM-1:0] blk_pix_t;

  logic clk;
  logic rst_n;
  logic rx_hold     = 1'b0;
  logic press_start = 1'b0;

  int src_idle  = 28;
  int snk_idle  = 59;
  int cycle_cnt = 0;
  int errors    = 0;
  int blocks_in = 0;
  int rows_ok   = 0;
  int mode_cnt [4];

  half_row_t pending_half_rows [$];
  dir_row_t  dir_tbl [N_DIR];

  ilp_in_if  in_ch ();
  ilp_out_if out_ch ();

  intra_16x16_luma_predictor_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d half-rows outstanding", cycle_cnt,
               pending_half_rows.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic blk_pix_t predict_block(nbr_item_t it);
    blk_pix_t blk;
    int up_px [16];
    int lf_px [16];
    int h, v, a, b, c, dc, st, sl, tp, lp, x, y, k, p;
    st = 0;
    sl = 0;
    h  = 0;
    v  = 0;
    for (k = 0; k < 16; k++) begin
      up_px[k] = int'(it.top[8*k +: 8]);
      lf_px[k] = it.left_av ? int'(it.left[8*k +: 8]) : 0;
      st += up_px[k];
      sl += lf_px[k];
    end
    for (k = 0; k < 8; k++) begin
      tp = (k < 7) ? up_px[6-k] : int'(it.corner);
      lp = (k < 7) ? lf_px[6-k] : int'(it.corner);
      h += (k + 1) * (up_px[8+k] - tp);
      v += (k + 1) * (lf_px[8+k] - lp);
    end
    b = (5 * h + 32) >>> 6;
    c = (5 * v + 32) >>> 6;
    a = 16 * (lf_px[15] + up_px[15]);
    if (it.top_av && it.left_av) dc = (st + sl + 16) >> 5;
    else if (it.top_av) dc = (st + 8) >> 4;
    else if (it.left_av) dc = (sl + 8) >> 4;
    else dc = 1 << (SAMPLE_BITS - 1);
    for (y = 0; y < BLK_DIM; y++) begin
      for (x = 0; x < BLK_DIM; x++) begin
        case (it.mode)
          MODE_VERT: p = it.top_av ? up_px[x] : 0;
          MODE_HORZ: p = lf_px[y];
          MODE_DC:   p = dc;
          default: begin
            p = (a + b * (x - 7) + c * (y - 7) + 16) >>> 5;
            if (p < 0) p = 0;
            if (p > PIX_MAX) p = PIX_MAX;
          end
        endcase
        blk[y][x] = pix_t'(p);
      end
    end
    return blk;
  endfunction

  function automatic void queue_half_rows(blk_pix_t blk);
    half_row_t hr;
    int k, x;
    for (k = 0; k < BEATS; k++) begin
      hr.row  = k[4:1];
      hr.half = k[0];
      for (x = 0; x < 4; x++) begin
        hr.first4[8*x +: 8] = blk[k[4:1]][HALF_PIX*k[0] + x];
        hr.last4[8*x +: 8]  = blk[k[4:1]][HALF_PIX*k[0] + 4 + x];
      end
      hr.last = (k == BEATS - 1);
      pending_half_rows.push_back(hr);
    end
  endfunction

  function automatic logic [127:0] rand_edge();
    logic [127:0] e;
    int style, base, step, k, p;
    style = $urandom_range(0, 3);
    base  = $urandom_range(0, 255);
    step  = int'($urandom_range(0, 40)) - 20;
    for (k = 0; k < 16; k++) begin
      case (style)
        0:       p = $urandom_range(0, 255);
        1:       p = base + step * k;
        2:       p = base + int'($urandom_range(0, 8)) - 4;
        default: p = $urandom_range(0, 1) * PIX_MAX;
      endcase
      if (p < 0) p = 0;
      if (p > PIX_MAX) p = PIX_MAX;
      e[8*k +: 8] = pix_t'(p);
    end
    return e;
  endfunction

  function automatic nbr_item_t rand_item();
    nbr_item_t it;
    it.mode    = pred_mode_t'($urandom_range(0, 3));
    it.top_av  = ($urandom_range(0, 3) != 0);
    it.left_av = ($urandom_range(0, 3) != 0);
    it.corner  = pix_t'($urandom_range(0, 255));
    it.top     = rand_edge();
    it.left    = rand_edge();
    return it;
  endfunction

  function automatic void check_half_row(half_row_t got);
    half_row_t exp_hr;
    if (pending_half_rows.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("unexpected beat: row %0d half %0d first4 %h last4 %h last %b",
                 got.row, got.half, got.first4, got.last4, got.last);
      return;
    end
    exp_hr = pending_half_rows.pop_front();
    if (got != exp_hr) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch: expected row %0d half %0d %h %h last %b, got row %0d half %0d %h %h last %b",
                 exp_hr.row, exp_hr.half, exp_hr.first4, exp_hr.last4, exp_hr.last,
                 got.row, got.half, got.first4, got.last4, got.last);
    end else begin
      rows_ok++;
    end
  endfunction

  task automatic send_item(nbr_item_t it, logic fixed, pix_t fill);
    while ($urandom_range(0, 99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.top_px_0_3    <= it.top[31:0];
    in_ch.top_px_4_7    <= it.top[63:32];
    in_ch.top_px_8_11   <= it.top[95:64];
    in_ch.top_px_12_15  <= it.top[127:96];
    in_ch.left_px_0_3   <= it.left[31:0];
    in_ch.left_px_4_7   <= it.left[63:32];
    in_ch.left_px_8_11  <= it.left[95:64];
    in_ch.left_px_12_15 <= it.left[127:96];
    in_ch.corner_px     <= it.corner;
    in_ch.pred_mode     <= it.mode;
    in_ch.top_avail     <= it.top_av;
    in_ch.left_avail    <= it.left_av;
    in_ch.valid         <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (fixed) queue_half_rows({(BLK_DIM*BLK_DIM){fill}});
    else queue_half_rows(predict_block(it));
    blocks_in++;
    mode_cnt[it.mode]++;
  endtask

  // sink side: check accepted beats, then pick ready for the next cycle
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        check_half_row('{out_ch.row_index, out_ch.half_index, out_ch.pixels_first4,
                         out_ch.pixels_last4, out_ch.block_last});
      out_ch.ready <= rst_n && !rx_hold && ($urandom_range(0, 99) >= snk_idle);
    end
  end

  // long back-pressure stretch on the result side
  initial begin
    wait (press_start === 1'b1);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.top_px_0_3    = '0;
    in_ch.top_px_4_7    = '0;
    in_ch.top_px_8_11   = '0;
    in_ch.top_px_12_15  = '0;
    in_ch.left_px_0_3   = '0;
    in_ch.left_px_4_7   = '0;
    in_ch.left_px_8_11  = '0;
    in_ch.left_px_12_15 = '0;
    in_ch.corner_px     = '0;
    in_ch.pred_mode     = MODE_VERT;
    in_ch.top_avail     = 1'b0;
    in_ch.left_avail    = 1'b0;
    foreach (mode_cnt[m]) mode_cnt[m] = 0;

    // mode, top avail, left avail, corner, top, left; then typed fill if known
    dir_tbl = '{
      '{'{MODE_VERT,  1'b1, 1'b1, 8'h00, ALL_FF,  ZERO},    1'b1, 8'hFF},
      '{'{MODE_VERT,  1'b0, 1'b1, 8'h00, MIX,     MIX},     1'b1, 8'h00},
      '{'{MODE_VERT,  1'b1, 1'b0, 8'h00, RAMP_UP, MIX},     1'b0, 8'h00},
      '{'{MODE_HORZ,  1'b1, 1'b1, 8'h00, ZERO,    ALL_FF},  1'b1, 8'hFF},
      '{'{MODE_HORZ,  1'b1, 1'b0, 8'h00, MIX,     MIX},     1'b1, 8'h00},
      '{'{MODE_HORZ,  1'b0, 1'b1, 8'h00, MIX,     RAMP_DN}, 1'b0, 8'h00},
      '{'{MODE_DC,    1'b0, 1'b0, 8'h00, ALL_FF,  ALL_FF},  1'b1, 8'h80},
      '{'{MODE_DC,    1'b1, 1'b1, 8'h00, ALL_FF,  ALL_FF},  1'b1, 8'hFF},
      '{'{MODE_DC,    1'b1, 1'b1, 8'hFF, ZERO,    ZERO},    1'b1, 8'h00},
      '{'{MODE_DC,    1'b1, 1'b0, 8'h00, ALL_FF,  MIX},     1'b1, 8'hFF},
      '{'{MODE_DC,    1'b0, 1'b1, 8'h00, MIX,     FLAT80},  1'b1, 8'h80},
      '{'{MODE_DC,    1'b1, 1'b1, 8'h00, RAMP_UP, MIX},     1'b0, 8'h00},
      '{'{MODE_DC,    1'b1, 1'b0, 8'h00, MIX,     RAMP_DN}, 1'b0, 8'h00},
      '{'{MODE_PLANE, 1'b1, 1'b1, 8'h80, FLAT80,  FLAT80},  1'b1, 8'h80},
      '{'{MODE_PLANE, 1'b1, 1'b1, 8'hFF, ALL_FF,  ALL_FF},  1'b1, 8'hFF},
      '{'{MODE_PLANE, 1'b1, 1'b1, 8'h00, ZERO,    ZERO},    1'b1, 8'h00},
      '{'{MODE_PLANE, 1'b1, 1'b1, 8'h00, EDGE_HI, EDGE_HI}, 1'b0, 8'h00},
      '{'{MODE_PLANE, 1'b1, 1'b1, 8'hFF, EDGE_LO, EDGE_LO}, 1'b0, 8'h00},
      '{'{MODE_PLANE, 1'b1, 1'b1, 8'h40, RAMP_UP, RAMP_DN}, 1'b0, 8'h00},
      '{'{MODE_PLANE, 1'b1, 1'b0, 8'h80, RAMP_UP, MIX},     1'b0, 8'h00},
      '{'{MODE_PLANE, 1'b0, 1'b1, 8'h20, RAMP_DN, RAMP_UP}, 1'b0, 8'h00},
      '{'{MODE_PLANE, 1'b0, 1'b0, 8'hFF, MIX,     MIX},     1'b0, 8'h00},
      '{'{MODE_VERT,  1'b1, 1'b1, 8'hFF, MIX,     ALL_FF},  1'b0, 8'h00}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) send_item(dir_tbl[i].item, dir_tbl[i].fixed, dir_tbl[i].fill);
    repeat (80) send_item(rand_item(), 1'b0, 8'h00);

    src_idle = 59;
    snk_idle = 28;
    repeat (80) send_item(rand_item(), 1'b0, 8'h00);

    // fill the block while results are held off
    src_idle = 0;
    snk_idle = 0;
    press_start <= 1'b1;
    repeat (12) send_item(rand_item(), 1'b0, 8'h00);
    repeat (70) send_item(rand_item(), 1'b0, 8'h00);
    in_ch.valid <= 1'b0;

    while (pending_half_rows.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d blocks (%0d directed): vertical %0d, horizontal %0d, dc %0d, plane %0d",
             blocks_in, N_DIR, mode_cnt[MODE_VERT], mode_cnt[MODE_HORZ], mode_cnt[MODE_DC],
             mode_cnt[MODE_PLANE]);
    $display("%0d half-rows matched, %0d errors, in %0d cycles", rows_ok, errors, cycle_cnt);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ilp_pkg.sv
design/ilp_if.sv
design/ilp_setup.sv
design/ilp_emit.sv
design/intra_16x16_luma_predictor_unit.sv
verif/tb.sv
